@@ design/wbp_pkg.sv @@
// ----------------------------------------------------------------------------
// wbp_pkg
// Shared types and constants for the windowed busy percentage block.
// ----------------------------------------------------------------------------
package wbp_pkg;

  localparam int WINDOW_BITS  = 5;
  localparam int PERCENT_BITS = 7;
  localparam int QUOT_BITS    = 7;   // quotient bits of the percent divider
  localparam int MUL_SHIFT_A  = 6;   // 100 = 64 + 32 + 4
  localparam int MUL_SHIFT_B  = 5;
  localparam int MUL_SHIFT_C  = 2;

  localparam logic [WINDOW_BITS-1:0]  WINDOW_RESET = 5'd16;
  localparam logic [PERCENT_BITS-1:0] PERCENT_FULL = 7'd100;
  localparam logic [PERCENT_BITS-1:0] PERCENT_NONE = 7'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SHIFT,
    ST_MUL_A,
    ST_MUL_B,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

@@ design/windowed_busy_percent.sv @@
// ----------------------------------------------------------------------------
// windowed_busy_percent
// Busy share of elapsed ticks over a sliding window of counter snapshots.
// ----------------------------------------------------------------------------
//  channel | valid / ready          | payload
//  --------+------------------------+----------------------------------------
//  input   | in_valid_i / in_ready_o  | user/nice/system/idle_ticks_i
//  output  | out_valid_o / out_ready_i| busy_percent_o
//  config  | cfg_valid_i / cfg_ready_o| window_length_i
//
//  Each item passes through accept, history read, the bit-serial sums and
//  differences over SUM_BITS bits, two adds for the multiply by 100, seven
//  restoring divide steps and the result load. The bit-serial adder pass is
//  the longest of these steps.
//  Reset clears the history valid bits at once; no clearing pass is needed.
//  A finished result waits in the output register; the next item is accepted
//  meanwhile and holds in the last step only if that register is still full.
// ----------------------------------------------------------------------------
module windowed_busy_percent
  import wbp_pkg::*;
#(
  parameter int HISTORY_DEPTH = 16,
  parameter int COUNTER_BITS  = 48
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [COUNTER_BITS-1:0]   user_ticks_i,
  input  logic [COUNTER_BITS-1:0]   nice_ticks_i,
  input  logic [COUNTER_BITS-1:0]   system_ticks_i,
  input  logic [COUNTER_BITS-1:0]   idle_ticks_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [PERCENT_BITS-1:0]   busy_percent_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [WINDOW_BITS-1:0]    window_length_i
);

  localparam int SUM_BITS = COUNTER_BITS + 2;
  localparam int NQ_W     = SUM_BITS + QUOT_BITS;
  localparam int IDX_W    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CMP_W    = (IDX_W + 1 > WINDOW_BITS) ? IDX_W + 1 : WINDOW_BITS;
  localparam int CNT_W    = $clog2(SUM_BITS);

  localparam logic [CMP_W-1:0] DEPTH_C   = CMP_W'(HISTORY_DEPTH);
  localparam logic [CNT_W-1:0] SHIFT_END = CNT_W'(SUM_BITS - 1);
  localparam logic [CNT_W-1:0] DIV_END   = CNT_W'(QUOT_BITS - 1);

  state_e state_q, state_d;

  logic [WINDOW_BITS-1:0]   win_q;
  logic [IDX_W-1:0]         slot_q, idx_q, rd_idx;
  logic [CMP_W-1:0]         eff_win, win_ext;
  logic [HISTORY_DEPTH-1:0] vld_q;
  logic                     rd_vld_q;
  logic [2*SUM_BITS-1:0]    hist_mem [HISTORY_DEPTH];
  logic [2*SUM_BITS-1:0]    rd_q;

  logic [COUNTER_BITS-1:0]  u_q, n_q, s_q, i_q;
  logic [SUM_BITS-1:0]      busy_q, total_q;
  logic [SUM_BITS-1:0]      ob_q, ot_q;   // old values, refilled with deltas
  logic [1:0]               cb_q;
  logic                     ct_q, bb_q, bt_q, bc_q, otnz_q;
  logic [CNT_W-1:0]         cnt_q;

  logic [NQ_W-1:0]          num_q, dsh_q;
  logic [QUOT_BITS-1:0]     quo_q;

  logic                     out_valid_q;
  logic [PERCENT_BITS-1:0]  out_data_q;

  logic                     in_acc, out_free;
  logic [2:0]               bsum;
  logic [1:0]               tsum, dbd, dtd, cmpd;
  logic                     b_bit, t_bit;
  logic [NQ_W:0]            trial;
  logic                     take;
  logic [PERCENT_BITS-1:0]  result;
  logic [IDX_W-1:0]         slot_next;

  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign busy_percent_o = out_data_q;
  assign in_acc         = in_valid_i && in_ready_o;
  assign out_free       = !out_valid_q || out_ready_i;

  // window clamp to 1..HISTORY_DEPTH and slot selection
  always_comb begin
    win_ext = CMP_W'(win_q);
    if (win_ext == '0) begin
      eff_win = CMP_W'(1);
    end else if (win_ext > DEPTH_C) begin
      eff_win = DEPTH_C;
    end else begin
      eff_win = win_ext;
    end
    rd_idx    = (CMP_W'(slot_q) >= eff_win) ? '0 : slot_q;
    slot_next = (CMP_W'(idx_q) + CMP_W'(1) >= eff_win) ? '0 : idx_q + IDX_W'(1);
  end

  // serial adders, LSB first
  always_comb begin
    bsum  = {2'b0, u_q[0]} + {2'b0, n_q[0]} + {2'b0, s_q[0]} + {1'b0, cb_q};
    b_bit = bsum[0];
    tsum  = {1'b0, b_bit} + {1'b0, i_q[0]} + {1'b0, ct_q};
    t_bit = tsum[0];
    dbd   = {1'b0, b_bit} - {1'b0, ob_q[0]} - {1'b0, bb_q};
    dtd   = {1'b0, t_bit} - {1'b0, ot_q[0]} - {1'b0, bt_q};
    cmpd  = {1'b0, dbd[0]} - {1'b0, dtd[0]} - {1'b0, bc_q};
  end

  assign trial = {1'b0, num_q} - {1'b0, dsh_q};
  assign take  = !trial[NQ_W];

  // empty slot gives 0, busy delta not below total delta gives full scale
  always_comb begin
    if (!otnz_q) begin
      result = PERCENT_NONE;
    end else if (!bc_q) begin
      result = PERCENT_FULL;
    end else begin
      result = PERCENT_BITS'(quo_q);
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD:  state_d = ST_SHIFT;
      ST_SHIFT: begin
        if (cnt_q == SHIFT_END) begin
          state_d = ST_MUL_A;
        end
      end
      ST_MUL_A: state_d = ST_MUL_B;
      ST_MUL_B: state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == DIV_END) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= WINDOW_RESET;
      slot_q      <= '0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        win_q <= window_length_i;
      end
      if (in_acc) begin
        rd_vld_q <= vld_q[rd_idx];
      end
      if (state_q == ST_MUL_A) begin
        vld_q[idx_q] <= 1'b1;
        slot_q       <= slot_next;
      end
      if (state_q == ST_LOAD || state_q == ST_MUL_B) begin
        cnt_q <= '0;
      end else if (state_q == ST_SHIFT || state_q == ST_DIV) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // history memory
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q <= hist_mem[rd_idx];
    end
    if (state_q == ST_MUL_A) begin
      hist_mem[idx_q] <= {total_q, busy_q};
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          u_q   <= user_ticks_i;
          n_q   <= nice_ticks_i;
          s_q   <= system_ticks_i;
          i_q   <= idle_ticks_i;
          idx_q <= rd_idx;
        end
      end
      ST_LOAD: begin
        ob_q   <= rd_vld_q ? rd_q[SUM_BITS-1:0] : '0;
        ot_q   <= rd_vld_q ? rd_q[2*SUM_BITS-1:SUM_BITS] : '0;
        cb_q   <= 2'b0;
        ct_q   <= 1'b0;
        bb_q   <= 1'b0;
        bt_q   <= 1'b0;
        bc_q   <= 1'b0;
        otnz_q <= 1'b0;
      end
      ST_SHIFT: begin
        u_q     <= u_q >> 1;
        n_q     <= n_q >> 1;
        s_q     <= s_q >> 1;
        i_q     <= i_q >> 1;
        busy_q  <= {b_bit, busy_q[SUM_BITS-1:1]};
        total_q <= {t_bit, total_q[SUM_BITS-1:1]};
        ob_q    <= {dbd[0], ob_q[SUM_BITS-1:1]};
        ot_q    <= {dtd[0], ot_q[SUM_BITS-1:1]};
        otnz_q  <= otnz_q | ot_q[0];
        cb_q    <= bsum[2:1];
        ct_q    <= tsum[1];
        bb_q    <= dbd[1];
        bt_q    <= dtd[1];
        bc_q    <= cmpd[1];
      end
      ST_MUL_A: begin
        num_q <= {1'b0, ob_q, MUL_SHIFT_A'(0)} + {2'b0, ob_q, MUL_SHIFT_B'(0)};
        dsh_q <= {1'b0, ot_q, MUL_SHIFT_A'(0)};
      end
      ST_MUL_B: begin
        num_q <= num_q + {5'b0, ob_q, MUL_SHIFT_C'(0)};
      end
      ST_DIV: begin
        if (take) begin
          num_q <= trial[NQ_W-1:0];
        end
        quo_q <= {quo_q[QUOT_BITS-2:0], take};
        dsh_q <= dsh_q >> 1;
      end
      ST_DONE: begin
        if (out_free) begin
          out_data_q <= result;
        end
      end
      default: ;
    endcase
  end

  // checks
  a_accept_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_LOAD)
    else $error("accepted item did not start the history read");

  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy_percent_o <= PERCENT_FULL)
    else $error("busy percent above full scale");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(slot_q) < DEPTH_C)
    else $error("slot index beyond history depth");

  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> out_valid_q && state_q == ST_IDLE)
    else $error("finished item not moved to output register");

endmodule
